// ===== hdl/nds_pkg.sv =====
// nds_pkg: shared types, constants and helpers for the note dispenser
`timescale 1ns / 1ps
`default_nettype none
package nds_pkg;

  localparam int NOTE_KINDS = 7;
  localparam int IDX_W      = 3;
  localparam int AMT_W      = 24;
  localparam int ADD_W      = 16;
  localparam int FIELD_W    = 16;
  localparam int CNT_W      = 16;
  localparam int VAL_W      = 7;
  localparam int RECIP_W    = 32;
  localparam int MAX_W      = (CNT_W > ADD_W) ? CNT_W : ADD_W;
  localparam int ACC_W      = MAX_W + 10;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [AMT_W-1:0]   TOTAL_MAX = {AMT_W{1'b1}};
  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(NOTE_KINDS - 1);

  localparam logic [VAL_W-1:0] NOTE_VAL [NOTE_KINDS] = '{
    7'd100, 7'd50, 7'd20, 7'd10, 7'd5, 7'd2, 7'd1
  };

  // floor((2^32 - 1) / value), quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] NOTE_RECIP [NOTE_KINDS] = '{
    32'd42949672, 32'd85899345, 32'd214748364, 32'd429496729,
    32'd858993459, 32'd2147483647, 32'd4294967295
  };

  typedef enum logic [1:0] {
    MODE_WITHDRAW = 2'd0,
    MODE_DEPOSIT  = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_WITHDRAW,
    OP_DEPOSIT,
    OP_QUERY,
    OP_IGNORE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_TAKE,
    ST_REST,
    ST_ACCUM,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [AMT_W-1:0] amount;
    logic [ADD_W-1:0] add_count_100;
    logic [ADD_W-1:0] add_count_50;
    logic [ADD_W-1:0] add_count_20;
    logic [ADD_W-1:0] add_count_10;
    logic [ADD_W-1:0] add_count_5;
    logic [ADD_W-1:0] add_count_2;
    logic [ADD_W-1:0] add_count_1;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [AMT_W-1:0]   total_value;
    logic [FIELD_W-1:0] count_100;
    logic [FIELD_W-1:0] count_50;
    logic [FIELD_W-1:0] count_20;
    logic [FIELD_W-1:0] count_10;
    logic [FIELD_W-1:0] count_5;
    logic [FIELD_W-1:0] count_2;
    logic [FIELD_W-1:0] count_1;
  } res_t;

  typedef struct packed {
    op_t                              op;
    logic [AMT_W-1:0]                 amount;
    logic [NOTE_KINDS-1:0][ADD_W-1:0] adds;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [CNT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return (wide > 32'(FIELD_MAX)) ? FIELD_MAX : FIELD_W'(v);
  endfunction

  function automatic logic [AMT_W-1:0] sat_total(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : AMT_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nds_front.sv =====
// nds_front: request intake stage, decodes the mode and feeds the queue
`timescale 1ns / 1ps
`default_nettype none
module nds_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire nds_pkg::req_t   req,
  input  wire nds_pkg::qstat_t qst,
  output logic                 push,
  output nds_pkg::entry_t      push_entry
);

  logic            fe_valid;
  nds_pkg::entry_t fe_entry;
  nds_pkg::entry_t fe_entry_next;
  logic            accept;

  assign req_stall  = fe_valid && qst.full;
  assign accept     = req_valid && !req_stall;
  assign push       = fe_valid && !qst.full;
  assign push_entry = fe_entry;

  always_comb begin
    fe_entry_next.amount = req.amount;
    fe_entry_next.adds   = {req.add_count_1, req.add_count_2, req.add_count_5,
                            req.add_count_10, req.add_count_20, req.add_count_50,
                            req.add_count_100};
    unique case (nds_pkg::mode_t'(req.mode))
      nds_pkg::MODE_WITHDRAW: fe_entry_next.op = nds_pkg::OP_WITHDRAW;
      nds_pkg::MODE_DEPOSIT:  fe_entry_next.op = nds_pkg::OP_DEPOSIT;
      nds_pkg::MODE_QUERY:    fe_entry_next.op = nds_pkg::OP_QUERY;
      nds_pkg::MODE_UNUSED:   fe_entry_next.op = nds_pkg::OP_IGNORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (accept) begin
      fe_valid <= 1'b1;
    end else if (push) begin
      fe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_entry <= fe_entry_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nds_queue.sv =====
// nds_queue: short queue of decoded requests between front and back
`timescale 1ns / 1ps
`default_nettype none
module nds_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nds_pkg::entry_t push_entry,
  input  wire logic            pop,
  output nds_pkg::qstat_t      qst,
  output nds_pkg::entry_t      head
);

  nds_pkg::entry_t                entries [nds_pkg::QDEPTH];
  logic [nds_pkg::QPTR_W-1:0]     wr_ptr;
  logic [nds_pkg::QPTR_W-1:0]     rd_ptr;
  logic [nds_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign qst.valid = (count != '0);
  assign qst.full  = (count == nds_pkg::QCNT_W'(nds_pkg::QDEPTH));
  assign do_push   = push && !qst.full;
  assign do_pop    = pop && qst.valid;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nds_back.sv =====
// nds_back: stock registers, greedy withdrawal and deposit/query sequencer, result register
`timescale 1ns / 1ps
`default_nettype none
module nds_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire nds_pkg::qstat_t qst,
  input  wire nds_pkg::entry_t head,
  output logic                 pop,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output nds_pkg::res_t        res
);

  localparam int QP_W = nds_pkg::AMT_W + nds_pkg::RECIP_W;
  localparam int QV_W = nds_pkg::AMT_W + nds_pkg::VAL_W;
  localparam int TV_W = nds_pkg::CNT_W + nds_pkg::VAL_W;
  localparam int AP_W = nds_pkg::MAX_W + nds_pkg::VAL_W;

  nds_pkg::back_state_t state;
  nds_pkg::back_state_t state_next;
  logic                 fin;

  nds_pkg::op_t                                         job_op;
  logic [nds_pkg::AMT_W-1:0]                            amount;
  logic [nds_pkg::NOTE_KINDS-1:0][nds_pkg::ADD_W-1:0]   adds;
  logic [nds_pkg::IDX_W-1:0]                            idx;
  logic [nds_pkg::AMT_W-1:0]                            rest;
  logic [nds_pkg::AMT_W-1:0]                            q_est;
  logic [nds_pkg::ACC_W-1:0]                            acc;
  logic [nds_pkg::NOTE_KINDS-1:0][nds_pkg::CNT_W-1:0]   counts;
  logic [nds_pkg::NOTE_KINDS-1:0][nds_pkg::CNT_W-1:0]   stock;

  logic [nds_pkg::VAL_W-1:0]   val;
  logic [QP_W-1:0]             q_prod;
  logic [QV_W-1:0]             qv;
  logic [nds_pkg::AMT_W-1:0]   rem;
  logic [nds_pkg::AMT_W-1:0]   q_fix;
  logic [nds_pkg::CNT_W-1:0]   take;
  logic [TV_W-1:0]             take_val;
  logic [nds_pkg::MAX_W-1:0]   acc_src;
  logic [AP_W-1:0]             acc_prod;
  logic [nds_pkg::MAX_W:0]     dep_sum;
  logic [nds_pkg::CNT_W-1:0]   dep_new;
  logic                        last;
  logic                        covered;
  logic [nds_pkg::FIELD_W-1:0] cnt_out [nds_pkg::NOTE_KINDS];
  nds_pkg::res_t               res_next;

  assign last    = (idx == nds_pkg::IDX_LAST);
  assign covered = (rest == '0);
  assign val     = nds_pkg::NOTE_VAL[idx];

  // quotient estimate, then one correction step
  assign q_prod   = QP_W'(rest) * QP_W'(nds_pkg::NOTE_RECIP[idx]);
  assign qv       = QV_W'(q_est) * QV_W'(val);
  assign rem      = rest - qv[nds_pkg::AMT_W-1:0];
  assign q_fix    = (rem >= nds_pkg::AMT_W'(val)) ? q_est + 1'b1 : q_est;
  assign take     = (32'(q_fix) < 32'(stock[idx])) ? nds_pkg::CNT_W'(q_fix) : stock[idx];
  assign take_val = TV_W'(counts[idx]) * TV_W'(val);

  assign acc_src  = (job_op == nds_pkg::OP_DEPOSIT) ? nds_pkg::MAX_W'(adds[idx])
                                                    : nds_pkg::MAX_W'(stock[idx]);
  assign acc_prod = AP_W'(acc_src) * AP_W'(val);
  assign dep_sum  = (nds_pkg::MAX_W + 1)'(stock[idx]) + (nds_pkg::MAX_W + 1)'(adds[idx]);
  assign dep_new  = (dep_sum > (nds_pkg::MAX_W + 1)'(nds_pkg::CNT_MAX)) ? nds_pkg::CNT_MAX
                                                                        : nds_pkg::CNT_W'(dep_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fin        = 1'b0;
    unique case (state)
      nds_pkg::ST_IDLE: begin
        if (qst.valid) begin
          pop = 1'b1;
          unique case (head.op)
            nds_pkg::OP_WITHDRAW: state_next = nds_pkg::ST_QUOT;
            nds_pkg::OP_DEPOSIT:  state_next = nds_pkg::ST_ACCUM;
            nds_pkg::OP_QUERY:    state_next = nds_pkg::ST_ACCUM;
            nds_pkg::OP_IGNORE:   state_next = nds_pkg::ST_FINISH;
          endcase
        end
      end
      nds_pkg::ST_QUOT:  state_next = nds_pkg::ST_TAKE;
      nds_pkg::ST_TAKE:  state_next = nds_pkg::ST_REST;
      nds_pkg::ST_REST:  state_next = last ? nds_pkg::ST_FINISH : nds_pkg::ST_QUOT;
      nds_pkg::ST_ACCUM: state_next = last ? nds_pkg::ST_FINISH : nds_pkg::ST_ACCUM;
      nds_pkg::ST_FINISH: begin
        if (!res_valid || !res_stall) begin
          fin        = 1'b1;
          state_next = nds_pkg::ST_IDLE;
        end
      end
      default: state_next = nds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stock <= '0;
    end else if (state == nds_pkg::ST_ACCUM && job_op == nds_pkg::OP_DEPOSIT) begin
      stock[idx] <= dep_new;
    end else if (fin && job_op == nds_pkg::OP_WITHDRAW && covered) begin
      for (int i = 0; i < nds_pkg::NOTE_KINDS; i++) begin
        stock[i] <= stock[i] - counts[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_op <= head.op;
      amount <= head.amount;
      adds   <= head.adds;
      rest   <= head.amount;
      idx    <= '0;
      acc    <= '0;
      counts <= '0;
    end else begin
      unique case (state)
        nds_pkg::ST_QUOT: begin
          q_est <= q_prod[QP_W-1:nds_pkg::RECIP_W];
        end
        nds_pkg::ST_TAKE: begin
          counts[idx] <= take;
        end
        nds_pkg::ST_REST: begin
          rest <= rest - nds_pkg::AMT_W'(take_val);
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
        nds_pkg::ST_ACCUM: begin
          acc <= acc + nds_pkg::ACC_W'(acc_prod);
          if (!last) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_next = '0;
    for (int i = 0; i < nds_pkg::NOTE_KINDS; i++) begin
      cnt_out[i] = '0;
    end
    unique case (job_op)
      nds_pkg::OP_WITHDRAW: begin
        if (covered) begin
          res_next.ok          = 1'b1;
          res_next.total_value = amount;
          for (int i = 0; i < nds_pkg::NOTE_KINDS; i++) begin
            cnt_out[i] = nds_pkg::sat_field(counts[i]);
          end
        end
      end
      nds_pkg::OP_DEPOSIT, nds_pkg::OP_QUERY: begin
        res_next.ok          = 1'b1;
        res_next.total_value = nds_pkg::sat_total(acc);
        for (int i = 0; i < nds_pkg::NOTE_KINDS; i++) begin
          cnt_out[i] = nds_pkg::sat_field(stock[i]);
        end
      end
      nds_pkg::OP_IGNORE: begin
      end
    endcase
    res_next.count_100 = cnt_out[0];
    res_next.count_50  = cnt_out[1];
    res_next.count_20  = cnt_out[2];
    res_next.count_10  = cnt_out[3];
    res_next.count_5   = cnt_out[4];
    res_next.count_2   = cnt_out[5];
    res_next.count_1   = cnt_out[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res <= res_next;
    end
  end

  a_rest_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == nds_pkg::ST_REST) |=> (rest <= $past(rest)))
    else $error("remaining amount grew during withdrawal");

  a_take_in_stock: assert property (@(posedge clk) disable iff (rst)
    (state == nds_pkg::ST_REST) |-> (counts[idx] <= stock[idx]))
    else $error("notes taken exceed stock");

  a_stock_quiet: assert property (@(posedge clk) disable iff (rst)
    !(state == nds_pkg::ST_ACCUM || state == nds_pkg::ST_FINISH) |=> $stable(stock))
    else $error("stock changed outside deposit or commit");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (fin && job_op == nds_pkg::OP_WITHDRAW && !covered)
      |=> (!res.ok && res.total_value == '0 && res.count_1 == '0))
    else $error("failed withdrawal reported nonzero result");

endmodule
`default_nettype wire

// ===== hdl/note_dispenser_greedy_stock.sv =====
// note_dispenser_greedy_stock: top level of the note dispenser with limited stock
//
//   channel   handshake             payload       dir
//   request   req_valid/req_stall   req (req_t)   in
//   result    res_valid/res_stall   res (res_t)   out
//
// withdraw runs in the back end the quotient estimate, its correction and the
// remainder update for each note value, plus pop and finish steps
// deposit and query take one accumulate step per note value; mode 3 pops and finishes
// front register and queue buffer requests and take them until both are full
// reset (synchronous, high) empties the queue and clears the stock to zero
// a stalled result holds the back end in its finish step until taken
`timescale 1ns / 1ps
`default_nettype none
module note_dispenser_greedy_stock (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire nds_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_stall,
  output nds_pkg::res_t      res
);

  nds_pkg::qstat_t qst;
  nds_pkg::entry_t push_entry;
  nds_pkg::entry_t head;
  logic            push;
  logic            pop;

  nds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .qst        (qst),
    .push       (push),
    .push_entry (push_entry)
  );

  nds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .qst        (qst),
    .head       (head)
  );

  nds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qst       (qst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for the note dispenser with limited stock
`timescale 1ns / 1ps
module tb_top;
  import nds_pkg::*;

  localparam int unsigned NOTE_WORTH [7] = '{100, 50, 20, 10, 5, 2, 1};
  localparam logic [15:0] COUNT_TOP      = 16'hFFFF;
  localparam logic [23:0] AMOUNT_TOP     = 24'hFFFFFF;
  localparam logic [23:0] FULL_STOCK_SUM = 24'd12320580;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  logic [15:0] model_stock [7];
  res_t pending_results [$];
  int errors = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int hold_left = 0;

  note_dispenser_greedy_stock dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("note_dispenser_greedy_stock verification failed");
    $finish;
  end

  function automatic res_t predict_dispense(input req_t item);
    res_t out;
    logic [15:0] adds [7];
    logic [15:0] counts [7];
    logic [31:0] rest;
    logic [31:0] take;
    logic [31:0] sum;
    logic [16:0] grown;
    int i;
    adds = '{item.add_count_100, item.add_count_50, item.add_count_20, item.add_count_10,
             item.add_count_5, item.add_count_2, item.add_count_1};
    counts = '{default: '0};
    out = '0;
    sum = '0;
    case (item.mode)
      MODE_WITHDRAW: begin
        rest = 32'(item.amount);
        for (i = 0; i < 7; i++) begin
          take = rest / NOTE_WORTH[i];
          if (take > 32'(model_stock[i])) take = 32'(model_stock[i]);
          counts[i] = take[15:0];
          rest = rest - take * NOTE_WORTH[i];
        end
        if (rest == 0) begin
          for (i = 0; i < 7; i++) model_stock[i] = model_stock[i] - counts[i];
          out.ok = 1'b1;
          sum = 32'(item.amount);
        end else begin
          counts = '{default: '0};
        end
      end
      MODE_DEPOSIT: begin
        for (i = 0; i < 7; i++) begin
          grown = 17'(model_stock[i]) + 17'(adds[i]);
          model_stock[i] = grown[16] ? COUNT_TOP : grown[15:0];
          sum = sum + 32'(adds[i]) * NOTE_WORTH[i];
          counts[i] = model_stock[i];
        end
        out.ok = 1'b1;
      end
      MODE_QUERY: begin
        for (i = 0; i < 7; i++) begin
          sum = sum + 32'(model_stock[i]) * NOTE_WORTH[i];
          counts[i] = model_stock[i];
        end
        out.ok = 1'b1;
      end
      default: ;
    endcase
    out.total_value = (sum > 32'(AMOUNT_TOP)) ? AMOUNT_TOP : sum[23:0];
    out.count_100 = counts[0];
    out.count_50  = counts[1];
    out.count_20  = counts[2];
    out.count_10  = counts[3];
    out.count_5   = counts[4];
    out.count_2   = counts[5];
    out.count_1   = counts[6];
    return out;
  endfunction

  function automatic req_t noisy_request(input logic [1:0] mode, input logic [23:0] amount);
    req_t r;
    r.mode          = mode;
    r.amount        = amount;
    r.add_count_100 = 16'($urandom);
    r.add_count_50  = 16'($urandom);
    r.add_count_20  = 16'($urandom);
    r.add_count_10  = 16'($urandom);
    r.add_count_5   = 16'($urandom);
    r.add_count_2   = 16'($urandom);
    r.add_count_1   = 16'($urandom);
    return r;
  endfunction

  function automatic req_t deposit_request(input logic [15:0] c100, c50, c20, c10, c5, c2,
                                           c1);
    req_t r;
    r = noisy_request(MODE_DEPOSIT, 24'($urandom));
    r.add_count_100 = c100;
    r.add_count_50  = c50;
    r.add_count_20  = c20;
    r.add_count_10  = c10;
    r.add_count_5   = c5;
    r.add_count_2   = c2;
    r.add_count_1   = c1;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    int i;
    logic [31:0] worth;
    pick = $urandom_range(0, 99);
    r = noisy_request(MODE_WITHDRAW, 24'($urandom));
    if (pick < 35) begin
      r.amount = 24'($urandom_range(0, 1500));
    end else if (pick < 41) begin
      r.mode = MODE_WITHDRAW;
    end else if (pick < 45) begin
      // near the whole stock value, drains the stock or just misses
      worth = '0;
      for (i = 0; i < 7; i++) worth = worth + 32'(model_stock[i]) * NOTE_WORTH[i];
      if (worth > 3) worth = worth - $urandom_range(0, 3);
      r.amount = worth[23:0];
    end else if (pick < 75) begin
      r = deposit_request(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                          16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                          16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                          16'($urandom_range(0, 15)));
    end else if (pick < 80) begin
      r.mode = MODE_DEPOSIT;
    end else if (pick < 93) begin
      r.mode = MODE_QUERY;
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  task automatic send_request(input req_t item);
    int gap;
    int pick;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(20, 60);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = item;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(predict_dispense(item));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // receiver side: random stalls, long runs, and a counted hold-off
  initial begin
    int pick;
    int run_left;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else if (!stalls_on) begin
        res_stall = 1'b0;
      end else if (run_left > 0) begin
        res_stall = 1'b1;
        run_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) run_left = $urandom_range(20, 60);
        res_stall = (pick < 25);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none got %h", $time, res);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(res.ok));
        check_field("total_value", 32'(want.total_value), 32'(res.total_value));
        check_field("count_100", 32'(want.count_100), 32'(res.count_100));
        check_field("count_50", 32'(want.count_50), 32'(res.count_50));
        check_field("count_20", 32'(want.count_20), 32'(res.count_20));
        check_field("count_10", 32'(want.count_10), 32'(res.count_10));
        check_field("count_5", 32'(want.count_5), 32'(res.count_5));
        check_field("count_2", 32'(want.count_2), 32'(res.count_2));
        check_field("count_1", 32'(want.count_1), 32'(res.count_1));
      end
    end
  end

  task automatic test_empty_stock();
    send_request(noisy_request(MODE_QUERY, 24'($urandom)));
    send_request(noisy_request(MODE_WITHDRAW, 24'd0));
    send_request(noisy_request(MODE_WITHDRAW, 24'd1));
    send_request(noisy_request(MODE_WITHDRAW, AMOUNT_TOP));
  endtask

  task automatic test_greedy_shortfall();
    // one 50 and three 20s: 60 fails greedily, 70 works
    send_request(deposit_request(16'd0, 16'd1, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0));
    send_request(noisy_request(MODE_WITHDRAW, 24'd60));
    send_request(noisy_request(MODE_WITHDRAW, 24'd70));
    send_request(noisy_request(MODE_QUERY, 24'($urandom)));
  endtask

  task automatic test_deposit_saturation();
    send_request(deposit_request(COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP,
                                 COUNT_TOP, COUNT_TOP));
    send_request(deposit_request(COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP,
                                 COUNT_TOP, COUNT_TOP));
    send_request(noisy_request(MODE_QUERY, 24'($urandom)));
    send_request(noisy_request(MODE_WITHDRAW, AMOUNT_TOP));
    send_request(noisy_request(MODE_WITHDRAW, FULL_STOCK_SUM));
    send_request(noisy_request(MODE_QUERY, 24'($urandom)));
    send_request(deposit_request('0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_unused_mode();
    send_request('1);
    send_request(deposit_request(16'd3, 16'd2, 16'd5, 16'd1, 16'd4, 16'd7, 16'd9));
    send_request(noisy_request(MODE_UNUSED, 24'($urandom)));
    send_request(noisy_request(MODE_WITHDRAW, 24'd388));
    send_request(noisy_request(MODE_QUERY, 24'($urandom)));
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_left = 200;
    repeat (12) send_request(random_request());
    wait_drained();
    repeat (6) send_request(random_request());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 14; phase++) begin
      gaps_on = (phase % 3) != 0;
      stalls_on = (phase % 4) != 1;
      repeat (100) send_request(random_request());
      if (phase % 5 == 4) wait_drained();
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    for (i = 0; i < 7; i++) model_stock[i] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_stock();
    test_greedy_shortfall();
    test_deposit_saturation();
    test_unused_mode();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    req_valid = 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("note_dispenser_greedy_stock verification clean");
    end else begin
      $display("note_dispenser_greedy_stock verification failed");
    end
    $finish;
  end

endmodule
